// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lstpw_pkg.sv =====
// shared types, constants and codes of the two-point weight block
package lstpw_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int SQ_W       = PROD_W - 1;
  localparam int SUMU_W     = 40;
  localparam int SUMS_W     = 41;
  localparam int DIFF_W     = SUMS_W + 2;
  localparam int DEN_W      = SUMS_W + 1;
  localparam int WEIGHT_W   = 16;
  localparam int CODE_W     = 2;
  localparam int SHIFT_W    = 6;
  localparam int MARGIN_W   = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [WEIGHT_W-1:0] ONE_Q15         = WEIGHT_W'(32768);
  localparam logic [WEIGHT_W-1:0] HALF_Q15        = WEIGHT_W'(16384);
  localparam logic [SHIFT_W-1:0]  TOL_SHIFT_RESET = SHIFT_W'(27);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET    = MARGIN_W'(8192);
  localparam logic [MARGIN_W-1:0] MARGIN_MAX      = MARGIN_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOL_SHIFT    = 1'b0,
    REG_CLAMP_MARGIN = 1'b1
  } cfg_reg_t;

  typedef enum logic [CODE_W-1:0] {
    CASE_PLUS_ZERO  = 2'd0,
    CASE_MINUS_ZERO = 2'd1,
    CASE_NEAR       = 2'd2,
    CASE_SOLVED     = 2'd3
  } case_code_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_minus;
    logic signed [SAMPLE_W-1:0] sample_plus;
    logic signed [SAMPLE_W-1:0] sample_center;
    logic                       last_vector;
  } in_word_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_minus;
    logic [WEIGHT_W-1:0] weight_plus;
    logic [CODE_W-1:0]   case_code;
    logic                was_clamped;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_PREP,
    ST_NORM,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load_prod;
    logic accum;
    logic prep;
    logic norm;
    logic check;
    logic div_step;
    logic div_first;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ===== rtl/lstpw_ctrl.sv =====
// controller: sequences accumulate, solve steps and the output register
module lstpw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  lstpw_pkg::dp_status_t status,
  output lstpw_pkg::dp_cmd_t    cmd
);
  import lstpw_pkg::*;

  ctrl_state_t          state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_prod = in_valid;
        if (in_valid) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.last ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check    = 1'b1;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (div_cnt == '0);
        div_cnt_next  = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.load_out = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

endmodule

// ===== rtl/lstpw_dpath.sv =====
// datapath: products, saturating sums, classification, divider, result register
module lstpw_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lstpw_pkg::in_word_t                  in_data,
  output lstpw_pkg::out_word_t                 out_data,
  input  logic                                 cfg_write_en,
  input  logic [lstpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lstpw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  lstpw_pkg::dp_cmd_t                   cmd,
  output lstpw_pkg::dp_status_t                status
);
  import lstpw_pkg::*;

  // configuration
  logic [SHIFT_W-1:0]  tol_shift;
  logic [MARGIN_W-1:0] margin;

  // product stage
  logic signed [PROD_W-1:0] sq_m_full, sq_p_full;
  logic [SQ_W-1:0]          sq_mm, sq_pp;
  logic signed [PROD_W-1:0] pr_mp, pr_mz;
  logic                     prod_last;

  // sums
  logic [SUMU_W-1:0]        sum_mm, sum_pp;
  logic signed [SUMS_W-1:0] sum_mp, sum_mz;
  logic [SUMU_W:0]          add_mm, add_pp;
  logic [SUMS_W:0]          add_mp, add_mz;
  logic [SUMU_W-1:0]        sat_mm, sat_pp;
  logic [SUMS_W-1:0]        sat_mp, sat_mz;

  // solve registers
  logic signed [DIFF_W-1:0] num, den;
  logic [SUMS_W-1:0]        abs_mp, abs_mz;
  logic                     pp_zero, mm_zero;
  logic [DEN_W-1:0]         aden, anum;
  logic signed [DIFF_W-1:0] num_n;
  logic [DIFF_W-1:0]        num_neg_v, den_neg_v;
  logic [SUMS_W-1:0]        tol_p, tol_z;
  logic                     near, den_zero, num_neg, num_zero, num_big;
  logic [DIFF_W-1:0]        rem;
  logic [WEIGHT_W-1:0]      quo;
  logic [DIFF_W:0]          trial, trial_sub;
  logic                     trial_ge;

  // result selection
  logic [MARGIN_W-1:0] margin_eff;
  logic [WEIGHT_W-1:0] lo, hi;
  logic                round_up;
  logic [WEIGHT_W:0]   rounded;
  logic [WEIGHT_W-1:0] wp;
  logic [CODE_W-1:0]   code;
  logic                clamped;

  assign status.last = prod_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_shift <= TOL_SHIFT_RESET;
      margin    <= MARGIN_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TOL_SHIFT:    tol_shift <= cfg_data[SHIFT_W-1:0];
        REG_CLAMP_MARGIN: margin    <= cfg_data[MARGIN_W-1:0];
        default:          ;
      endcase
    end
  end

  // four 16x16 products, registered before the adders
  assign sq_m_full = in_data.sample_minus * in_data.sample_minus;
  assign sq_p_full = in_data.sample_plus * in_data.sample_plus;

  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      sq_mm     <= sq_m_full[SQ_W-1:0];
      sq_pp     <= sq_p_full[SQ_W-1:0];
      pr_mp     <= in_data.sample_minus * in_data.sample_plus;
      pr_mz     <= in_data.sample_minus * in_data.sample_center;
      prod_last <= in_data.last_vector;
    end
  end

  // saturating accumulate
  assign add_mm = {1'b0, sum_mm} + (SUMU_W + 1)'(sq_mm);
  assign add_pp = {1'b0, sum_pp} + (SUMU_W + 1)'(sq_pp);
  assign add_mp = {sum_mp[SUMS_W-1], sum_mp}
                + {{(SUMS_W + 1 - PROD_W){pr_mp[PROD_W-1]}}, pr_mp};
  assign add_mz = {sum_mz[SUMS_W-1], sum_mz}
                + {{(SUMS_W + 1 - PROD_W){pr_mz[PROD_W-1]}}, pr_mz};

  assign sat_mm = add_mm[SUMU_W] ? {SUMU_W{1'b1}} : add_mm[SUMU_W-1:0];
  assign sat_pp = add_pp[SUMU_W] ? {SUMU_W{1'b1}} : add_pp[SUMU_W-1:0];

  always_comb begin
    unique case (add_mp[SUMS_W:SUMS_W-1])
      2'b01:   sat_mp = {1'b0, {(SUMS_W - 1){1'b1}}};
      2'b10:   sat_mp = {1'b1, {(SUMS_W - 1){1'b0}}};
      default: sat_mp = add_mp[SUMS_W-1:0];
    endcase
    unique case (add_mz[SUMS_W:SUMS_W-1])
      2'b01:   sat_mz = {1'b0, {(SUMS_W - 1){1'b1}}};
      2'b10:   sat_mz = {1'b1, {(SUMS_W - 1){1'b0}}};
      default: sat_mz = add_mz[SUMS_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      sum_mm <= '0;
      sum_pp <= '0;
      sum_mp <= '0;
      sum_mz <= '0;
    end else if (cmd.accum) begin
      sum_mm <= sat_mm;
      sum_pp <= sat_pp;
      sum_mp <= sat_mp;
      sum_mz <= sat_mz;
    end
  end

  // prep: differences against mm and reference magnitudes
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num     <= {{2{sum_mz[SUMS_W-1]}}, sum_mz} - {3'b000, sum_mm};
      den     <= {{2{sum_mp[SUMS_W-1]}}, sum_mp} - {3'b000, sum_mm};
      abs_mp  <= sum_mp[SUMS_W-1] ? (~sum_mp + SUMS_W'(1)) : sum_mp;
      abs_mz  <= sum_mz[SUMS_W-1] ? (~sum_mz + SUMS_W'(1)) : sum_mz;
      pp_zero <= (sum_pp == '0);
      mm_zero <= (sum_mm == '0);
    end
  end

  // norm: magnitudes, and sign flip so the denominator is non-negative
  assign num_neg_v = ~num + DIFF_W'(1);
  assign den_neg_v = ~den + DIFF_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      anum  <= num[DIFF_W-1] ? num_neg_v[DEN_W-1:0] : num[DEN_W-1:0];
      aden  <= den[DIFF_W-1] ? den_neg_v[DEN_W-1:0] : den[DEN_W-1:0];
      num_n <= den[DIFF_W-1] ? num_neg_v : num;
    end
  end

  // check: near-equality and the cases that skip the quotient
  assign tol_p = abs_mp >> tol_shift;
  assign tol_z = abs_mz >> tol_shift;

  // divider: one quotient bit a step, first step without the doubling
  assign trial     = cmd.div_first ? {1'b0, rem} : {rem, 1'b0};
  assign trial_ge  = (trial >= (DIFF_W + 1)'(aden));
  assign trial_sub = trial - (DIFF_W + 1)'(aden);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      near     <= (DEN_W'(tol_p) > aden) || (DEN_W'(tol_z) > anum);
      den_zero <= (aden == '0);
      num_neg  <= num_n[DIFF_W-1];
      num_zero <= (num_n == '0);
      num_big  <= $signed({num_n[DIFF_W-1], num_n}) >= $signed({1'b0, aden, 1'b0});
      rem      <= num_n;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_sub[DIFF_W-1:0] : trial[DIFF_W-1:0];
      quo <= {quo[WEIGHT_W-2:0], trial_ge};
    end
  end

  // result selection
  assign margin_eff = (margin > MARGIN_MAX) ? MARGIN_MAX : margin;
  assign lo         = HALF_Q15 - WEIGHT_W'(margin_eff);
  assign hi         = HALF_Q15 + WEIGHT_W'(margin_eff);
  assign round_up   = ({rem, 1'b0} >= (DIFF_W + 1)'(aden));
  assign rounded    = {1'b0, quo} + (WEIGHT_W + 1)'(round_up);

  always_comb begin
    wp      = '0;
    code    = CASE_SOLVED;
    clamped = 1'b0;
    priority if (pp_zero) begin
      code = CASE_PLUS_ZERO;
    end else if (mm_zero) begin
      wp   = ONE_Q15;
      code = CASE_MINUS_ZERO;
    end else if (near) begin
      code = CASE_NEAR;
    end else if (den_zero) begin
      priority if (num_zero) begin
        wp = HALF_Q15;
      end else if (num_neg) begin
        wp      = lo;
        clamped = 1'b1;
      end else begin
        wp      = hi;
        clamped = 1'b1;
      end
    end else if (num_neg) begin
      wp      = lo;
      clamped = 1'b1;
    end else if (num_big) begin
      wp      = hi;
      clamped = 1'b1;
    end else if (quo < lo) begin
      wp      = lo;
      clamped = 1'b1;
    end else if ((quo > hi) || ((quo == hi) && (rem != '0))) begin
      wp      = hi;
      clamped = 1'b1;
    end else begin
      wp = rounded[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.weight_minus <= ONE_Q15 - wp;
      out_data.weight_plus  <= wp;
      out_data.case_code    <= code;
      out_data.was_clamped  <= clamped;
    end
  end

endmodule

// ===== rtl/ls_two_point_interp_weight.sv =====
// top level: two-point least-squares interpolation weight unit
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid / in_ready   | in_data: sample triple + last
//   out     | output    | out_valid / out_ready | out_data: weights, case, clamp
//   cfg     | input     | cfg_write_en only     | cfg_index, cfg_data
//
// an ordinary word is handled in order: its four products are registered, then added
// into the saturating sums; one word is in flight at a time
// a word marked last goes through these steps until its result word sits in the output
// register: accumulate, three classify stages, 16 divider steps, result select
// the 16-step radix-2 divider for the right weight sets the latency of a point
// the output register lets the next point's words be taken while a result
// word waits; a second finished result holds the controller until it drains
// synchronous active-high reset restores the register defaults and zero sums
module ls_two_point_interp_weight (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lstpw_pkg::in_word_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lstpw_pkg::out_word_t             out_data,
  input  logic                             cfg_write_en,
  input  logic [lstpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lstpw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lstpw_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: state machine, divider step count, output valid
  lstpw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: products, sums, classification, divider, result word
  lstpw_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .in_data      (in_data),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== rtl/lstpw_checker.sv =====
// port-level checker for the two-point weight unit, bound to the top level
`include "assert_macros.svh"

module lstpw_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input lstpw_pkg::out_word_t out_data
);
  import lstpw_pkg::*;

  logic             in_fire;
  logic [WEIGHT_W:0] weight_sum;

  assign in_fire    = in_valid && in_ready;
  assign weight_sum = (WEIGHT_W + 1)'(out_data.weight_minus)
                    + (WEIGHT_W + 1)'(out_data.weight_plus);

  // a stalled result word holds
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // the two weights always make one
  `CHK_IMPL(a_weight_sum, clk, rst, out_valid, weight_sum == (WEIGHT_W + 1)'(ONE_Q15), "weights do not sum to one")

  // only a solved point can be clamped
  `CHK_IMPL(a_clamp_code, clk, rst, out_valid && out_data.was_clamped, out_data.case_code == CASE_SOLVED, "clamp flag outside solved case")

  // zero plus energy gives a zero right weight
  `CHK_IMPL(a_plus_zero, clk, rst, out_valid && (out_data.case_code == CASE_PLUS_ZERO), out_data.weight_plus == '0, "plus-zero case with nonzero weight")

  // a taken word is accumulated before the next one is taken
  `CHK_NEXT(a_one_in_flight, clk, rst, in_fire, !in_ready, "input taken on consecutive cycles")

endmodule

bind ls_two_point_interp_weight lstpw_checker u_lstpw_checker (.*);
